// ----- rtl/core/bilinear_image_resampler_macros.svh -----
// Assertion helpers for the resampler checker.
// Each expects clk and rst_n in the scope where it is used.
`ifndef BILINEAR_IMAGE_RESAMPLER_MACROS_SVH
`define BILINEAR_IMAGE_RESAMPLER_MACROS_SVH

// Same-cycle implication.
`define BIR_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BIR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/bir_pkg.sv -----
package bir_pkg;

  localparam int DEF_MAX_SOURCE_WIDTH  = 256;
  localparam int DEF_MAX_SOURCE_HEIGHT = 256;
  localparam int DEF_FRACTION_BITS     = 16;

  localparam int OPCODE_W    = 1;
  localparam int COORD_W     = 12;
  localparam int PIX_W       = 24;
  localparam int CHAN_W      = 8;
  localparam int NUM_CHAN    = 3;
  localparam int SRC_SIZE_W  = 9;
  localparam int TGT_SIZE_W  = 13;
  localparam int SIZE_CMP_W  = 13;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;

  localparam logic [SRC_SIZE_W-1:0] RST_SOURCE_SIZE = 9'd256;
  localparam logic [TGT_SIZE_W-1:0] RST_TARGET_SIZE = 13'd256;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SOURCE_WIDTH  = 2'd0,
    REG_SOURCE_HEIGHT = 2'd1,
    REG_TARGET_WIDTH  = 2'd2,
    REG_TARGET_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef enum logic [OPCODE_W-1:0] {
    OP_STORE   = 1'b0,
    OP_COMPUTE = 1'b1
  } opcode_t;

endpackage

// ----- rtl/core/bilinear_image_resampler.sv -----
// Bilinear image resampler.
// Input channel (in_valid/in_ready): a store transfer (in_opcode OP_STORE) writes in_pixel_in
// to the source image at (in_row, in_column); stores outside the programmed source size are
// dropped. A store does not occupy the block; in_ready stays high.
// A compute transfer (OP_COMPUTE) asks for the destination pixel at (in_row, in_column).
// The block maps each axis with a restoring divider (one quotient bit per cycle), forms four
// weights and blends three channels on one shared multiplier. After a compute transfer
// in_ready stays low through MUL, DIV and MAP for each axis (DIV is skipped when that
// target size is 0 or 1), then WGT, READ, MAC and OUT; OUT waits while the output register
// is full. The result sits in an output register on out_valid/out_ready; a new item is
// accepted while it waits, but the next compute holds in its last step until it is taken.
// Configuration (cfg_valid/cfg_ready, always ready) writes source and target sizes; write only
// while idle. Reset sets all sizes to 256 and empties the output register; the source image
// is not cleared and must be written before it is read.
module bilinear_image_resampler
  import bir_pkg::*;
#(
  parameter int MAX_SOURCE_WIDTH  = DEF_MAX_SOURCE_WIDTH,
  parameter int MAX_SOURCE_HEIGHT = DEF_MAX_SOURCE_HEIGHT,
  parameter int FRACTION_BITS     = DEF_FRACTION_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [OPCODE_W-1:0]    in_opcode,
  input  logic [COORD_W-1:0]     in_row,
  input  logic [COORD_W-1:0]     in_column,
  input  logic [PIX_W-1:0]       in_pixel_in,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [PIX_W-1:0]       out_pixel_out,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int MAX_SRC   = (MAX_SOURCE_WIDTH > MAX_SOURCE_HEIGHT) ?
                             MAX_SOURCE_WIDTH : MAX_SOURCE_HEIGHT;
  localparam int SB        = $clog2(MAX_SRC);
  localparam int SZW       = $clog2(MAX_SRC + 1);
  localparam int QW        = SB + FRACTION_BITS;
  localparam int PW        = COORD_W + SB;
  localparam int FW        = FRACTION_BITS + 1;
  localparam int WW        = 2 * FRACTION_BITS + 2;
  localparam int MA        = (FW > COORD_W) ? FW : COORD_W;
  localparam int MB        = WW;
  localparam int PRODW     = CHAN_W + WW;
  localparam int ACCW      = PRODW + 2;
  localparam int HIW       = ACCW - 2 * FRACTION_BITS;
  localparam int DEPTH     = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
  localparam int AW        = $clog2(DEPTH);
  localparam int RW        = $clog2(MAX_SOURCE_HEIGHT);
  localparam int CW        = $clog2(MAX_SOURCE_WIDTH);
  localparam int CNTW      = $clog2(QW + 1);
  localparam int NUM_TAPS  = 4;
  localparam int MAC_STEPS = NUM_TAPS * NUM_CHAN;
  localparam int READ_STEPS = NUM_TAPS;

  localparam logic [FW-1:0] ONE_FIX = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic [AW-1:0] STRIDE  = AW'(MAX_SOURCE_WIDTH);
  localparam logic [AW-1:0] STRIDE1 = AW'(MAX_SOURCE_WIDTH + 1);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_MUL  = 8'b0000_0010,
    ST_DIV  = 8'b0000_0100,
    ST_MAP  = 8'b0000_1000,
    ST_WGT  = 8'b0001_0000,
    ST_READ = 8'b0010_0000,
    ST_MAC  = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_t;

  function automatic logic [SZW-1:0] eff_src(input logic [SRC_SIZE_W-1:0] v,
                                             input logic [SIZE_CMP_W-1:0] maxv);
    logic [SIZE_CMP_W-1:0] ve;
    ve = SIZE_CMP_W'(v);
    if (ve < SIZE_CMP_W'(2)) return SZW'(2);
    else if (ve > maxv) return SZW'(maxv);
    else return SZW'(ve);
  endfunction

  state_t state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic axis_r, axis_nxt;
  logic load_out;
  logic out_valid_r;
  logic [PIX_W-1:0] out_pixel_r;

  logic [SRC_SIZE_W-1:0] src_w_r, src_h_r;
  logic [TGT_SIZE_W-1:0] tgt_w_r, tgt_h_r;
  logic [SZW-1:0] sw_eff, sh_eff;

  logic [COORD_W-1:0] row_r, col_r;
  logic [TGT_SIZE_W-1:0] rem_r;
  logic [QW-1:0] num_r;
  logic [SB-1:0] l_r, c_r;
  logic [FW-1:0] u_r, t_r;
  logic [WW-1:0] w_r [NUM_TAPS];
  logic [AW-1:0] base_r;
  logic [PIX_W-1:0] px_r [NUM_TAPS];
  logic [PRODW-1:0] prod_r;
  logic [ACCW-1:0] acc_r;
  logic [CHAN_W-1:0] res_r [NUM_CHAN];

  logic [PIX_W-1:0] img_mem [DEPTH];
  logic [PIX_W-1:0] rd_data_r;
  logic [AW-1:0] rd_addr, wr_addr;
  logic wr_en, in_fire;

  logic [COORD_W-1:0] coord_sel, k_sel;
  logic [TGT_SIZE_W-1:0] tgt_sel, dvs;
  logic [SZW-1:0] old_sel;
  logic [SB-1:0] old_m1, old_m2, idx, cell_idx;
  logic [FW-1:0] frac, t_inv, u_inv;
  logic [TGT_SIZE_W:0] div_sh, div_diff;
  logic div_ge;
  logic [TGT_SIZE_W-1:0] div_rem;
  logic [MA-1:0] mul_a;
  logic [MB-1:0] mul_b;
  logic [MA+MB-1:0] mul_out;
  logic [PW-1:0] prod_p;
  logic [CHAN_W-1:0] mac_byte;
  logic [3:0] mac_j;
  logic [1:0] rd_slot;
  logic [ACCW-1:0] acc_sum;
  logic [HIW-1:0] acc_hi;
  logic [CHAN_W-1:0] chan_sat;

  assign in_ready      = (state_r == ST_IDLE);
  assign in_fire       = in_valid && in_ready;
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pixel_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= RST_SOURCE_SIZE;
      src_h_r <= RST_SOURCE_SIZE;
      tgt_w_r <= RST_TARGET_SIZE;
      tgt_h_r <= RST_TARGET_SIZE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SOURCE_WIDTH:  src_w_r <= cfg_data[SRC_SIZE_W-1:0];
        REG_SOURCE_HEIGHT: src_h_r <= cfg_data[SRC_SIZE_W-1:0];
        REG_TARGET_WIDTH:  tgt_w_r <= cfg_data[TGT_SIZE_W-1:0];
        REG_TARGET_HEIGHT: tgt_h_r <= cfg_data[TGT_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign sw_eff = eff_src(src_w_r, SIZE_CMP_W'(MAX_SOURCE_WIDTH));
  assign sh_eff = eff_src(src_h_r, SIZE_CMP_W'(MAX_SOURCE_HEIGHT));

  // Store path
  assign wr_en   = in_fire && (in_opcode == OP_STORE) &&
                   (SIZE_CMP_W'(in_row) < SIZE_CMP_W'(sh_eff)) &&
                   (SIZE_CMP_W'(in_column) < SIZE_CMP_W'(sw_eff));
  assign wr_addr = AW'(in_row[RW-1:0]) * STRIDE + AW'(in_column[CW-1:0]);

  always_comb begin
    unique case (cnt_r[1:0])
      2'd0:    rd_addr = base_r;
      2'd1:    rd_addr = base_r + AW'(1);
      2'd2:    rd_addr = base_r + STRIDE1;
      default: rd_addr = base_r + STRIDE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) img_mem[wr_addr] <= in_pixel_in;
    rd_data_r <= img_mem[rd_addr];
  end

  // Axis mapping: row axis first, then column axis
  assign coord_sel = axis_r ? col_r : row_r;
  assign tgt_sel   = axis_r ? tgt_w_r : tgt_h_r;
  assign old_sel   = axis_r ? sw_eff : sh_eff;
  assign dvs       = (tgt_sel == '0) ? '0 : tgt_sel - TGT_SIZE_W'(1);
  assign k_sel     = (SIZE_CMP_W'(coord_sel) > dvs) ? dvs[COORD_W-1:0] : coord_sel;
  assign old_m1    = SB'(old_sel - SZW'(1));
  assign old_m2    = SB'(old_sel - SZW'(2));

  assign div_sh   = {rem_r, num_r[QW-1]};
  assign div_ge   = div_sh >= {1'b0, dvs};
  assign div_diff = div_sh - {1'b0, dvs};
  assign div_rem  = div_ge ? div_diff[TGT_SIZE_W-1:0] : div_sh[TGT_SIZE_W-1:0];

  assign idx      = num_r[QW-1:FRACTION_BITS];
  assign cell_idx = (idx > old_m2) ? old_m2 : idx;
  assign frac     = FW'(num_r - {cell_idx, {FRACTION_BITS{1'b0}}});

  assign t_inv = ONE_FIX - t_r;
  assign u_inv = ONE_FIX - u_r;

  // Blend step: issue index is cnt_r, accumulate index lags by one
  assign mac_j   = cnt_r[3:0] - 4'd1;
  assign rd_slot = cnt_r[1:0] - 2'd1;

  always_comb begin
    unique case (cnt_r[3:2])
      2'd0:    mac_byte = px_r[cnt_r[1:0]][CHAN_W-1:0];
      2'd1:    mac_byte = px_r[cnt_r[1:0]][2*CHAN_W-1:CHAN_W];
      2'd2:    mac_byte = px_r[cnt_r[1:0]][3*CHAN_W-1:2*CHAN_W];
      default: mac_byte = '0;
    endcase
  end

  // Shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_MUL: begin
        mul_a = MA'(k_sel);
        mul_b = MB'(old_m1);
      end
      ST_WGT: begin
        unique case (cnt_r[1:0])
          2'd0: begin
            mul_a = MA'(t_inv);
            mul_b = MB'(u_inv);
          end
          2'd1: begin
            mul_a = MA'(t_r);
            mul_b = MB'(u_inv);
          end
          2'd2: begin
            mul_a = MA'(t_r);
            mul_b = MB'(u_r);
          end
          default: begin
            mul_a = MA'(t_inv);
            mul_b = MB'(u_r);
          end
        endcase
      end
      ST_MAC: begin
        mul_a = MA'(mac_byte);
        mul_b = MB'(w_r[cnt_r[1:0]]);
      end
      default: ;
    endcase
  end

  assign mul_out = mul_a * mul_b;
  assign prod_p  = mul_out[PW-1:0];

  assign acc_sum  = acc_r + ACCW'(prod_r);
  assign acc_hi   = acc_sum[ACCW-1:2*FRACTION_BITS];
  assign chan_sat = (|acc_hi[HIW-1:CHAN_W]) ? '1 : acc_hi[CHAN_W-1:0];

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    axis_nxt  = axis_r;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_opcode == OP_COMPUTE)) begin
          state_nxt = ST_MUL;
          axis_nxt  = 1'b0;
        end
      end
      ST_MUL: begin
        if (dvs == '0) begin
          state_nxt = ST_MAP;
        end else begin
          state_nxt = ST_DIV;
          cnt_nxt   = CNTW'(QW);
        end
      end
      ST_DIV: begin
        cnt_nxt = cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) state_nxt = ST_MAP;
      end
      ST_MAP: begin
        if (!axis_r) begin
          axis_nxt  = 1'b1;
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_WGT;
          cnt_nxt   = '0;
        end
      end
      ST_WGT: begin
        cnt_nxt = cnt_r + CNTW'(1);
        if (cnt_r[1:0] == 2'd3) begin
          state_nxt = ST_READ;
          cnt_nxt   = '0;
        end
      end
      ST_READ: begin
        cnt_nxt = cnt_r + CNTW'(1);
        if (cnt_r == CNTW'(READ_STEPS)) begin
          state_nxt = ST_MAC;
          cnt_nxt   = '0;
        end
      end
      ST_MAC: begin
        cnt_nxt = cnt_r + CNTW'(1);
        if (cnt_r == CNTW'(MAC_STEPS)) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    axis_r <= axis_nxt;
    if (in_fire) begin
      row_r <= in_row;
      col_r <= in_column;
    end
    unique case (state_r)
      ST_MUL: begin
        if (dvs == '0) begin
          num_r <= '0;
        end else begin
          rem_r <= TGT_SIZE_W'(prod_p >> SB);
          num_r <= {prod_p[SB-1:0], {FRACTION_BITS{1'b0}}};
        end
      end
      ST_DIV: begin
        rem_r <= div_rem;
        num_r <= {num_r[QW-2:0], div_ge};
      end
      ST_MAP: begin
        if (!axis_r) begin
          l_r <= cell_idx;
          u_r <= frac;
        end else begin
          c_r <= cell_idx;
          t_r <= frac;
        end
      end
      ST_WGT: begin
        w_r[cnt_r[1:0]] <= mul_out[WW-1:0];
        if (cnt_r[1:0] == 2'd0) base_r <= AW'(l_r) * STRIDE + AW'(c_r);
        acc_r <= '0;
      end
      ST_READ: begin
        if (cnt_r != '0) px_r[rd_slot] <= rd_data_r;
      end
      ST_MAC: begin
        if (cnt_r != CNTW'(MAC_STEPS)) prod_r <= mul_out[PRODW-1:0];
        if (cnt_r != '0) begin
          if (mac_j[1:0] == 2'd3) begin
            res_r[mac_j[3:2]] <= chan_sat;
            acc_r <= '0;
          end else begin
            acc_r <= acc_sum;
          end
        end
      end
      ST_OUT: begin
        if (load_out) out_pixel_r <= {res_r[2], res_r[1], res_r[0]};
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/core/bir_checker.sv -----
`include "bilinear_image_resampler_macros.svh"

module bir_checker
  import bir_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic [OPCODE_W-1:0] in_opcode,
  input logic                out_valid,
  input logic                out_ready,
  input logic [PIX_W-1:0]    out_pixel_out,
  input logic                cfg_ready
);

  // configuration is never back-pressured
  `BIR_ASSERT_IMPLY(a_cfg_ready, 1'b1, cfg_ready, "cfg_ready dropped")

  // a compute transfer occupies the block
  `BIR_ASSERT_NEXT(a_compute_busy, in_valid && in_ready && (in_opcode == OP_COMPUTE),
                   !in_ready, "in_ready high right after a compute transfer")

  // a store completes in the cycle of its transfer
  `BIR_ASSERT_NEXT(a_store_single, in_valid && in_ready && (in_opcode == OP_STORE),
                   in_ready, "in_ready low right after a store transfer")

  // a new result only comes out of a busy compute
  `BIR_ASSERT_IMPLY(a_result_origin, $rose(out_valid), $past(!in_ready),
                    "result appeared while the input side was idle")

  `BIR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_pixel_out), "stalled result changed")

endmodule

bind bilinear_image_resampler bir_checker u_bir_checker (.*);

// ----- verif/bilinear_image_resampler_tb.sv -----
`timescale 1ns / 100ps

module bilinear_image_resampler_tb;
  import bir_pkg::*;

  localparam int STRIDE      = DEF_MAX_SOURCE_WIDTH;
  localparam int IMG_WORDS   = DEF_MAX_SOURCE_WIDTH * DEF_MAX_SOURCE_HEIGHT;
  localparam int FRAC        = DEF_FRACTION_BITS;
  localparam longint unsigned ONE_FIX = 64'd1 << FRAC;
  localparam int SETTLE      = 100;
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    opcode_t            op;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [PIX_W-1:0]   pix;
  } pixel_req_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [OPCODE_W-1:0]    in_opcode = OP_STORE;
  logic [COORD_W-1:0]     in_row = '0;
  logic [COORD_W-1:0]     in_column = '0;
  logic [PIX_W-1:0]       in_pixel_in = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [PIX_W-1:0]       out_pixel_out;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  bilinear_image_resampler DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_row       (in_row),
    .in_column    (in_column),
    .in_pixel_in  (in_pixel_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_pixel_out(out_pixel_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  pixel_req_t       pending_items[$];
  logic [PIX_W-1:0] expected_pixels[$];
  logic [PIX_W-1:0] source_copy[IMG_WORDS];
  bit               filled[IMG_WORDS];
  int unsigned      eff_sw = 256, eff_sh = 256, eff_tw = 256, eff_th = 256;
  int               err_count = 0;
  bit               quiet_mode = 1'b0;
  int               gap_left = 0;
  int               stall_left = 0;
  int               silent_cycles = 0;
  pixel_req_t       next_req;
  logic [PIX_W-1:0] oldest_pixel;

  function automatic int unsigned eff_source(int unsigned v, int unsigned maxv);
    if (v < 2) return 2;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Map a destination coordinate to a cell index and a fraction in [0, 2^F].
  function automatic void map_axis(input longint unsigned k, input longint unsigned oldn,
                                   input longint unsigned newn,
                                   output longint unsigned cell_idx,
                                   output longint unsigned frac);
    longint unsigned pos;
    longint unsigned kk;
    kk = (k > newn - 1) ? newn - 1 : k;
    pos = (newn > 1) ? ((kk * (oldn - 1)) << FRAC) / (newn - 1) : 64'd0;
    cell_idx = pos >> FRAC;
    if (cell_idx > oldn - 2) cell_idx = oldn - 2;
    frac = pos - (cell_idx << FRAC);
  endfunction

  function automatic logic [PIX_W-1:0] resample_pixel(logic [COORD_W-1:0] row,
                                                       logic [COORD_W-1:0] col);
    longint unsigned l, c, u, t, acc;
    longint unsigned w[4];
    logic [PIX_W-1:0] p[4];
    logic [PIX_W-1:0] res;
    map_axis(row, eff_sh, eff_th, l, u);
    map_axis(col, eff_sw, eff_tw, c, t);
    w[0] = (ONE_FIX - t) * (ONE_FIX - u);
    w[1] = t * (ONE_FIX - u);
    w[2] = t * u;
    w[3] = (ONE_FIX - t) * u;
    p[0] = source_copy[l * STRIDE + c];
    p[1] = source_copy[l * STRIDE + c + 1];
    p[2] = source_copy[(l + 1) * STRIDE + c + 1];
    p[3] = source_copy[(l + 1) * STRIDE + c];
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      acc = 0;
      for (int n = 0; n < 4; n++) acc += longint'(p[n][ch*CHAN_W +: CHAN_W]) * w[n];
      acc = acc >> (2 * FRAC);
      res[ch*CHAN_W +: CHAN_W] = (acc > 255) ? 8'hFF : acc[7:0];
    end
    return res;
  endfunction

  // Input driver: predict on each accepted transfer, then present the next item.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (in_opcode == OP_STORE) begin
          if (in_row < eff_sh && in_column < eff_sw)
            source_copy[int'(in_row) * STRIDE + int'(in_column)] = in_pixel_in;
        end else begin
          expected_pixels.push_back(resample_pixel(in_row, in_column));
        end
      end
      if (!in_valid || in_ready) begin
        if (gap_left == 0 && !quiet_mode && pending_items.size() != 0 &&
            $urandom_range(0, 5) == 0)
          gap_left = $urandom_range(1, 15);
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          next_req = pending_items.pop_front();
          in_valid    <= 1'b1;
          in_opcode   <= next_req.op;
          in_row      <= next_req.row;
          in_column   <= next_req.col;
          in_pixel_in <= next_req.pix;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random backpressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %06h", $time, out_pixel_out);
          err_count++;
        end else begin
          oldest_pixel = expected_pixels.pop_front();
          if (out_pixel_out !== oldest_pixel) begin
            $display("%0t: pixel_out mismatch, expected %06h actual %06h",
                     $time, oldest_pixel, out_pixel_out);
            err_count++;
          end
        end
      end
      if (stall_left == 0 && !quiet_mode && $urandom_range(0, 9) == 0)
        stall_left = $urandom_range(1, 15);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        silent_cycles = 0;
      else
        silent_cycles++;
      if (silent_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic wait_idle;
    while (pending_items.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SOURCE_WIDTH:  eff_sw = eff_source(data[SRC_SIZE_W-1:0], DEF_MAX_SOURCE_WIDTH);
      REG_SOURCE_HEIGHT: eff_sh = eff_source(data[SRC_SIZE_W-1:0], DEF_MAX_SOURCE_HEIGHT);
      REG_TARGET_WIDTH:  eff_tw = (data == 0) ? 1 : data;
      REG_TARGET_HEIGHT: eff_th = (data == 0) ? 1 : data;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic set_sizes(input int unsigned sw, input int unsigned sh,
                           input int unsigned tw, input int unsigned th);
    wait_idle();
    write_reg(REG_SOURCE_WIDTH, CFG_DATA_W'(sw));
    write_reg(REG_SOURCE_HEIGHT, CFG_DATA_W'(sh));
    write_reg(REG_TARGET_WIDTH, CFG_DATA_W'(tw));
    write_reg(REG_TARGET_HEIGHT, CFG_DATA_W'(th));
  endtask

  task automatic queue_item(input opcode_t op, input int unsigned row,
                            input int unsigned col, input int unsigned pix);
    pixel_req_t req;
    req.op  = op;
    req.row = COORD_W'(row);
    req.col = COORD_W'(col);
    req.pix = PIX_W'(pix);
    pending_items.push_back(req);
    if (op == OP_STORE && req.row < eff_sh && req.col < eff_sw)
      filled[int'(req.row) * STRIDE + int'(req.col)] = 1'b1;
  endtask

  // Write every source pixel a compute could touch that has not been written yet.
  task automatic fill_source;
    for (int r = 0; r < eff_sh; r++)
      for (int c = 0; c < eff_sw; c++)
        if (!filled[r * STRIDE + c]) queue_item(OP_STORE, r, c, $urandom_range(0, 24'hFFFFFF));
  endtask

  task automatic run_phase(input int unsigned sw, input int unsigned sh,
                           input int unsigned tw, input int unsigned th,
                           input int n);
    int counted;
    int pick;
    int unsigned row_top, col_top;
    int unsigned r, c;
    set_sizes(sw, sh, tw, th);
    fill_source();
    row_top = (eff_th - 1 > 4095) ? 4095 : eff_th - 1;
    col_top = (eff_tw - 1 > 4095) ? 4095 : eff_tw - 1;
    counted = 0;
    while (counted < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        queue_item(OP_COMPUTE, $urandom_range(0, row_top), $urandom_range(0, col_top),
                   $urandom_range(0, 24'hFFFFFF));
        counted++;
      end else if (pick < 65) begin
        // coordinates past the target size saturate
        queue_item(OP_COMPUTE, $urandom_range(0, 4095), $urandom_range(0, 4095),
                   $urandom_range(0, 24'hFFFFFF));
        counted++;
      end else if (pick < 90) begin
        queue_item(OP_STORE, $urandom_range(0, eff_sh - 1), $urandom_range(0, eff_sw - 1),
                   $urandom_range(0, 24'hFFFFFF));
        counted++;
      end else begin
        r = $urandom_range(0, 4095);
        c = $urandom_range(0, 4095);
        if (r < eff_sh && c < eff_sw) counted++;
        queue_item(OP_STORE, r, c, $urandom_range(0, 24'hFFFFFF));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: small 4x3 source scaled to 7x5, extreme pixel values.
    set_sizes(4, 3, 7, 5);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 4; c++)
        queue_item(OP_STORE, r, c, (r == 1 && c == 2) ? 24'h5AC31E :
                   ((r + c) % 2 != 0) ? 24'hFFFFFF : 24'h000000);
    queue_item(OP_STORE, 3, 0, 24'hFFFFFF);          // row at source height: drop
    queue_item(OP_STORE, 0, 4, 24'hFFFFFF);          // column at source width: drop
    queue_item(OP_STORE, 12'hFFF, 12'hFFF, 24'hFFFFFF);
    queue_item(OP_COMPUTE, 0, 0, 24'h000000);
    queue_item(OP_COMPUTE, 4, 6, 24'hFFFFFF);
    queue_item(OP_COMPUTE, 2, 3, 24'h000000);
    queue_item(OP_COMPUTE, 1, 5, 24'h000000);
    queue_item(OP_COMPUTE, 12'hFFF, 12'hFFF, 24'h000000);
    queue_item(OP_COMPUTE, 0, 12'hFFF, 24'h000000);
    queue_item(OP_COMPUTE, 12'hFFF, 0, 24'h000000);

    run_phase(2, 2, 1, 1, 16);
    run_phase(0, 1, 0, 0, 16);
    run_phase(256, 2, 4096, 3, 16);
    run_phase(13'h1FFF, 2, 13'h1FFF, 2, 16);
    run_phase(2, 256, 2, 4096, 16);
    run_phase(3, 20, 5, 13'h1FFF, 16);
    run_phase(13'h1E02, 13'h1E03, 0, 1, 16);
    repeat (4)
      run_phase($urandom_range(2, 12), $urandom_range(2, 12), $urandom_range(1, 40),
                $urandom_range(1, 40), 16);
    quiet_mode = 1'b1;
    run_phase($urandom_range(2, 12), $urandom_range(2, 12), $urandom_range(1, 40),
              $urandom_range(1, 40), 16);

    wait_idle();
    if (err_count == 0 && expected_pixels.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/bir_pkg.sv
rtl/core/bilinear_image_resampler.sv
rtl/core/bir_checker.sv
verif/bilinear_image_resampler_tb.sv
